FILE: rtl/core/mov_pkg.sv
// Shared constants and types for the median-of-values block.
package mov_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 7;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic               ins;
      logic               shift;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/mov_ifs.sv
// Valid/ready channel interfaces for the input words and the result words.
interface mov_req_if;
   logic                        valid;
   logic                        ready;
   logic [mov_pkg::VALUE_W-1:0] value;
   logic                        last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface mov_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mov_pkg::VALUE_W-1:0] median;
   logic [mov_pkg::COUNT_W-1:0] count;
   logic                        overflow;

   modport source (output valid, output median, output count, output overflow, input ready);
   modport sink (input valid, input median, input count, input overflow, output ready);
endinterface

FILE: rtl/core/median_of_values_top.sv
// After the last of n stored words (at most MAX_POINTS) the row shifts until element
// floor((n-1)/2) is in cell zero; the result waits while the previous one is unaccepted.
// Throughput: one word per cycle while a set loads; after the last word the input stalls
// while the sorted row drains toward its head cells, until the result is registered.
// Reset (synchronous, active high) clears the fill count, the overflow flag, the state
// and the result valid; the cell values are not cleared and need no clearing pass.
module median_of_values_top #(
   parameter int MAX_POINTS = mov_pkg::MAX_POINTS_DEF
) (
   input logic         clock,
   input logic         reset,
   mov_req_if.sink     req_ch,
   mov_rsp_if.source   rsp_ch
);
   import mov_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // Control state. The count holds how many cells are occupied; the drop flag
   // remembers that a word arrived while every cell was already taken.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               drop_ff, drop_in;
   logic [CNT_W-1:0]   left_ff, left_in;

   // Result register, which decouples the row from the result channel.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_median_ff, rsp_median_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   cell_ctrl_type      ctrl;
   logic [VALUE_W-1:0] head0, head1;
   logic               req_fire;
   logic               full;
   logic [CNT_W-1:0]   count_next;
   logic               finish;
   logic [VALUE_W:0]   pair_sum;

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(MAX_POINTS));
   assign count_next   = full ? count_ff : count_ff + CNT_W'(1);

   // Every cell sees the incoming word. During the drain the whole row moves one
   // place toward the head per cycle until the middle element reaches cell zero.
   assign ctrl.ins   = req_fire && !full;
   assign ctrl.shift = (state_ff == ST_DRAIN) && (left_ff != '0);
   assign ctrl.value = req_ch.value;

   mov_chain #(
      .MAX_POINTS (MAX_POINTS),
      .CNT_W      (CNT_W)
   ) u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .count (count_ff),
      .head0 (head0),
      .head1 (head1)
   );

   // The drain ends once the lower middle element sits in cell zero; the result
   // register must be free (or emptied in this same cycle) to take the answer.
   assign finish = (state_ff == ST_DRAIN) && (left_ff == '0) &&
                   (!rsp_valid_ff || rsp_ch.ready);

   // The two middles are averaged over their full 65-bit sum, so nothing wraps.
   assign pair_sum = {1'b0, head0} + {1'b0, head1};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               count_in = count_next;
               drop_in  = drop_ff || full;
               if (req_ch.last) begin
                  // Shifts needed to bring element floor((n-1)/2) to the head.
                  left_in  = (count_next - CNT_W'(1)) >> 1;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (left_ff != '0) begin
               left_in = left_ff - CNT_W'(1);
            end else if (finish) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = count_ff[0] ? head0 : pair_sum[VALUE_W:1];
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_ovf_in    = drop_ff;
               count_in      = '0;
               drop_in       = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.median   = rsp_median_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

endmodule

FILE: rtl/core/mov_cell.sv
// One sorting cell: holds a single value and trades it with its neighbors.
module mov_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                          clock,
   input  mov_pkg::cell_ctrl_type        ctrl,
   input  logic [CNT_W-1:0]              count,
   input  logic                          prev_gt,
   input  logic [mov_pkg::VALUE_W-1:0]   prev_val,
   input  logic [mov_pkg::VALUE_W-1:0]   next_val,
   output logic                          gt,
   output logic [mov_pkg::VALUE_W-1:0]   val
);
   import mov_pkg::*;

   logic [VALUE_W-1:0] val_ff, val_in;
   logic               occupied;
   logic               at_end;

   assign occupied = CNT_W'(IDX) < count;
   assign at_end   = CNT_W'(IDX) == count;
   assign gt       = occupied && (val_ff > ctrl.value);
   assign val      = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.ins) begin
         if (prev_gt) begin
            val_in = prev_val;
         end else if (gt || at_end) begin
            val_in = ctrl.value;
         end
      end else if (ctrl.shift) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

FILE: rtl/core/mov_chain.sv
// Row of sorting cells kept in ascending order, head cell at index zero.
module mov_chain #(
   parameter int MAX_POINTS = mov_pkg::MAX_POINTS_DEF,
   parameter int CNT_W      = 7
) (
   input  logic                          clock,
   input  mov_pkg::cell_ctrl_type        ctrl,
   input  logic [CNT_W-1:0]              count,
   output logic [mov_pkg::VALUE_W-1:0]   head0,
   output logic [mov_pkg::VALUE_W-1:0]   head1
);
   import mov_pkg::*;

   logic [VALUE_W-1:0] val [MAX_POINTS];
   logic               gt  [MAX_POINTS];

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      logic               p_gt;
      logic [VALUE_W-1:0] p_val;
      logic [VALUE_W-1:0] n_val;

      if (i == 0) begin : g_first
         assign p_gt  = 1'b0;
         assign p_val = '0;
      end else begin : g_mid
         assign p_gt  = gt[i-1];
         assign p_val = val[i-1];
      end

      if (i == MAX_POINTS - 1) begin : g_tail
         assign n_val = '0;
      end else begin : g_body
         assign n_val = val[i+1];
      end

      mov_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count),
         .prev_gt  (p_gt),
         .prev_val (p_val),
         .next_val (n_val),
         .gt       (gt[i]),
         .val      (val[i])
      );
   end

   assign head0 = val[0];
   assign head1 = val[1];

endmodule

FILE: rtl/core/mov_checker.sv
// Port-level checks for the median block, bound to the top level.
module mov_checker #(
   parameter int MAX_POINTS = mov_pkg::MAX_POINTS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mov_pkg::VALUE_W-1:0]   rsp_median,
   input logic [mov_pkg::COUNT_W-1:0]   rsp_count,
   input logic                          rsp_overflow
);
   import mov_pkg::*;

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("result word changed while stalled");

   // Every result covers at least one stored word.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != '0)
      else $error("result with zero count");

   // Words are dropped only when the row is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_count == COUNT_W'(MAX_POINTS))
      else $error("overflow reported below capacity");

   // Nothing comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The input stalls while a set drains, so a new result word never appears in
   // the cycle after an input word was taken.
   a_no_result_on_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared straight after an input word");

endmodule

bind median_of_values_top mov_checker #(
   .MAX_POINTS (MAX_POINTS)
) u_mov_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_median   (rsp_ch.median),
   .rsp_count    (rsp_ch.count),
   .rsp_overflow (rsp_ch.overflow)
);

FILE: test/median_of_values_top_tb.sv
// Self-checking testbench for the median-of-values block, with its own sorted-store model.
module median_of_values_top_tb;
   import mov_pkg::*;

   // The store holds this many words; anything past it is dropped and flagged.
   localparam int STORE_DEPTH = MAX_POINTS_DEF;
   // Several times the slowest legal run: every word behind a long sender gap,
   // every set draining for half the store and every result behind a long stall.
   localparam int CYCLE_LIMIT = 200000;
   // After the last result, allow a full drain of the row and some margin.
   localparam int SETTLE_CYCLES = STORE_DEPTH / 2 + 16;

   // One input word as queued for the driver. When drain_first is set, the
   // driver holds this word back until every predicted result has come out.
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               drain_first;
   } data_word_type;

   // One predicted result word.
   typedef struct {
      logic [VALUE_W-1:0] median;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } median_result_type;

   logic clock = 1'b0;
   logic reset;

   mov_req_if req_ch ();
   mov_rsp_if rsp_ch ();

   median_of_values_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Words waiting to be sent, and medians the model says must still come out.
   data_word_type     words_to_send[$];
   median_result_type pending_medians[$];

   // Model state: the set loaded so far, kept in ascending order, and the
   // flag that records a word dropped because the store was full.
   logic [VALUE_W-1:0] sorted_vals[$];
   logic               store_dropped;

   // Idle and stall rates in percent, changed from phase to phase.
   int   send_idle_pct;
   int   recv_stall_pct;
   int   mismatches;
   int   cycle_count;
   logic word_taken;

   // Prints one line per problem and keeps the count that decides the verdict.
   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   // Folds one accepted word into the sorted set. A word equal to stored ones
   // goes after them. On the last word of a set, the median, the count and
   // the overflow flag are predicted and the set starts over empty.
   task automatic absorb_word(input logic [VALUE_W-1:0] v, input logic is_last);
      int                 pos;
      int                 n;
      logic [VALUE_W:0]   pair_sum;
      median_result_type  res;
      if (sorted_vals.size() >= STORE_DEPTH) begin
         store_dropped = 1'b1;
      end else begin
         pos = sorted_vals.size();
         while (pos > 0 && sorted_vals[pos-1] > v) pos--;
         sorted_vals.insert(pos, v);
      end
      if (is_last) begin
         n = sorted_vals.size();
         if (n % 2 == 1) begin
            res.median = sorted_vals[n/2];
         end else begin
            // The sum of the two middle words needs the 65th bit to avoid a wrap.
            pair_sum = {1'b0, sorted_vals[n/2-1]} + {1'b0, sorted_vals[n/2]};
            res.median = pair_sum[VALUE_W:1];
         end
         res.count = n[COUNT_W-1:0];
         res.overflow = store_dropped;
         pending_medians.push_back(res);
         sorted_vals.delete();
         store_dropped = 1'b0;
      end
   endtask

   // Compares one accepted result word with the oldest prediction.
   task automatic check_result(input logic [VALUE_W-1:0] median,
                               input logic [COUNT_W-1:0] count,
                               input logic overflow);
      median_result_type exp_res;
      if (pending_medians.size() == 0) begin
         report_mismatch($sformatf("result word with nothing expected: median %h count %0d",
                                   median, count));
      end else begin
         exp_res = pending_medians.pop_front();
         if (median !== exp_res.median)
            report_mismatch($sformatf("median %h, expected %h", median, exp_res.median));
         if (count !== exp_res.count)
            report_mismatch($sformatf("count %0d, expected %0d", count, exp_res.count));
         if (overflow !== exp_res.overflow)
            report_mismatch($sformatf("overflow %b, expected %b", overflow,
                                      exp_res.overflow));
      end
   endtask

   task automatic push_word(input logic [VALUE_W-1:0] v, input logic is_last,
                            input logic drain_first);
      data_word_type w;
      w.value = v;
      w.last = is_last;
      w.drain_first = drain_first;
      words_to_send.push_back(w);
   endtask

   // Queues a set of len words. The flavor picks how the values are drawn:
   // full-width random, a narrow range full of duplicates, values just under
   // the top of the range where the pair sum carries out, or a mix of extremes.
   task automatic load_set(input int len, input int flavor, input logic drain_first);
      logic [VALUE_W-1:0] v;
      for (int i = 0; i < len; i++) begin
         case (flavor)
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(7));
            2: v = ~64'($urandom_range(15));
            default: begin
               case ($urandom_range(3))
                  0: v = '0;
                  1: v = '1;
                  2: v = 64'h8000_0000_0000_0000;
                  default: v = {$urandom, $urandom};
               endcase
            end
         endcase
         push_word(v, i == len - 1, drain_first && i == 0);
      end
   endtask

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Driver: everything changes on the falling edge. A word stays on the bus
   // until the monitor has seen it taken; only then may the next one go up,
   // or the sender may idle instead.
   always @(negedge clock) begin : drive_words
      data_word_type next_word;
      if (!reset && (!req_ch.valid || word_taken)) begin
         if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct &&
             !(words_to_send[0].drain_first && pending_medians.size() != 0)) begin
            next_word = words_to_send.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.value <= next_word.value;
            req_ch.last <= next_word.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: samples both channels on the rising edge, feeds accepted input
   // words to the model and checks accepted result words against it.
   always @(posedge clock) begin
      word_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            absorb_word(req_ch.value, req_ch.last);
         if (rsp_ch.valid && rsp_ch.ready)
            check_result(rsp_ch.median, rsp_ch.count, rsp_ch.overflow);
      end
   end

   initial begin : stimulus
      int phase_words;
      int set_len;
      int pick;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      word_taken = 1'b0;
      store_dropped = 1'b0;
      mismatches = 0;
      cycle_count = 0;
      send_idle_pct = 16;
      recv_stall_pct = 56;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed sets: single words at both ends of the range, even pairs
      // whose sum needs the carry bit, a descending odd set, duplicates that
      // must keep their order, alternating bit patterns, a rounding-down case and three extremes.
      push_word('0, 1'b1, 1'b0);
      push_word('1, 1'b1, 1'b0);
      push_word('1, 1'b0, 1'b0);
      push_word('1, 1'b1, 1'b0);
      push_word('1, 1'b0, 1'b0);
      push_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
      push_word(64'd5, 1'b0, 1'b0);
      push_word(64'd3, 1'b0, 1'b0);
      push_word(64'd1, 1'b1, 1'b0);
      push_word(64'd7, 1'b0, 1'b0);
      push_word(64'd7, 1'b0, 1'b0);
      push_word(64'd2, 1'b0, 1'b0);
      push_word(64'd7, 1'b1, 1'b0);
      push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
      push_word(64'h5555_5555_5555_5555, 1'b1, 1'b0);
      push_word(64'd1, 1'b0, 1'b0);
      push_word(64'd2, 1'b1, 1'b0);
      push_word('1, 1'b0, 1'b0);
      push_word('0, 1'b0, 1'b0);
      push_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);

      // Three phases of random sets with different idle and stall patterns.
      // Between phases the bench waits until the block has nothing in flight.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_stall_pct = 56;
               // A store filled exactly, then filled with the last word
               // dropped, then overfilled by two words.
               load_set(STORE_DEPTH, 0, 1'b0);
               load_set(STORE_DEPTH + 1, 1, 1'b0);
               load_set(STORE_DEPTH + 2, 3, 1'b0);
               phase_words = 3 * STORE_DEPTH + 3;
            end
            1: begin
               send_idle_pct = 56;
               recv_stall_pct = 16;
               phase_words = 0;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               phase_words = 0;
            end
         endcase
         while (phase_words < 380) begin
            pick = $urandom_range(99);
            if (pick < 70)
               set_len = $urandom_range(8, 1);
            else if (pick < 92)
               set_len = $urandom_range(40, 9);
            else
               set_len = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH - 4);
            // The first random set of the later phases, and now and then
            // another, waits for the result stream to empty before it starts.
            load_set(set_len, $urandom_range(3),
                     phase_words == 0 || $urandom_range(11) == 0);
            phase_words += set_len;
         end
         while (words_to_send.size() != 0 || req_ch.valid || pending_medians.size() != 0)
            @(posedge clock);
      end

      // Let any stray result word show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_medians.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: median_of_values_top.f
rtl/core/mov_pkg.sv
rtl/core/mov_ifs.sv
rtl/core/mov_cell.sv
rtl/core/mov_chain.sv
rtl/core/median_of_values_top.sv
rtl/core/mov_checker.sv
test/median_of_values_top_tb.sv
